// ===== rtl/pn3_pkg.sv =====
// pn3_pkg: shared types and constants for the octave Perlin noise block.
// Depends on nothing; imported by every module of the block.
package pn3_pkg;

    localparam int TABLE_SIZE  = 256;
    localparam int MAX_OCTAVES = 8;

    // command queue between front and engine
    localparam int CMDQ_AW    = 1;
    localparam int CMDQ_DEPTH = 2 ** CMDQ_AW;

    // item kinds
    localparam logic ACT_LOAD   = 1'b0;
    localparam logic ACT_SAMPLE = 1'b1;

    // register indexes (address bit 2)
    localparam logic REG_OCTAVES = 1'b0;
    localparam logic REG_PERSIST = 1'b1;

    // register reset values
    localparam logic [3:0]  OCTAVES_RST = 4'd4;
    localparam logic [15:0] PERSIST_RST = 16'd16384;

    // one input beat after classification
    typedef struct packed {
        logic        is_sample;
        logic [7:0]  index;
        logic [7:0]  value;
        logic [23:0] x;
        logic [23:0] y;
        logic [23:0] z;
    } cmd_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_HASH,
        ST_MATH,
        ST_DIV,
        ST_DONE
    } eng_state_t;

endpackage

// ===== rtl/pn3_front.sv =====
// pn3_front: accepts input beats, classifies them and queues them for the engine.
// Depends on pn3_pkg (cmd_t, queue depth, item kinds).
module pn3_front
    import pn3_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    output logic        full,
    input  logic        action,
    input  logic [7:0]  table_index,
    input  logic [7:0]  table_value,
    input  logic [23:0] coord_x,
    input  logic [23:0] coord_y,
    input  logic [23:0] coord_z,
    output logic        cmd_valid,
    input  logic        cmd_ready,
    output cmd_t        cmd
);

    cmd_t                 q_mem [CMDQ_DEPTH];
    logic [CMDQ_AW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [CMDQ_AW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CMDQ_AW:0]     count_reg, count_next;
    logic                 do_push, do_pop;
    cmd_t                 in_cmd;

    // classify the incoming beat
    always_comb
    begin
        in_cmd.is_sample = (action == ACT_SAMPLE);
        in_cmd.index     = table_index;
        in_cmd.value     = table_value;
        in_cmd.x         = coord_x;
        in_cmd.y         = coord_y;
        in_cmd.z         = coord_z;
    end

    assign full      = (count_reg == (CMDQ_AW+1)'(CMDQ_DEPTH));
    assign cmd_valid = (count_reg != '0);
    assign do_push   = push && !full;
    assign do_pop    = cmd_valid && cmd_ready;
    assign cmd       = q_mem[rd_ptr_reg];

    // queue storage
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            q_mem[wr_ptr_reg] <= in_cmd;
        end
    end

    // pointers and fill count
    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop  ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (!do_push && do_pop)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

// ===== rtl/pn3_engine.sv =====
// pn3_engine: back end; owns the permutation table and evaluates octaves with
// one shared multiplier, then divides by the amplitude sum. Depends on pn3_pkg.
module pn3_engine
    import pn3_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cmd_valid,
    output logic               cmd_ready,
    input  cmd_t               cmd,
    input  logic [3:0]         octave_count,
    input  logic [15:0]        persistence,
    output logic               res_valid,
    input  logic               res_ready,
    output logic signed [15:0] res_noise
);

    // math step codes
    localparam logic [4:0] MS_X_T2   = 5'd0;
    localparam logic [4:0] MS_X_T3   = 5'd1;
    localparam logic [4:0] MS_X_FADE = 5'd2;
    localparam logic [4:0] MS_Y_T2   = 5'd3;
    localparam logic [4:0] MS_Y_T3   = 5'd4;
    localparam logic [4:0] MS_Y_FADE = 5'd5;
    localparam logic [4:0] MS_Z_T2   = 5'd6;
    localparam logic [4:0] MS_Z_T3   = 5'd7;
    localparam logic [4:0] MS_Z_FADE = 5'd8;
    localparam logic [4:0] MS_L0     = 5'd9;
    localparam logic [4:0] MS_L1     = 5'd10;
    localparam logic [4:0] MS_L2     = 5'd11;
    localparam logic [4:0] MS_L3     = 5'd12;
    localparam logic [4:0] MS_L4     = 5'd13;
    localparam logic [4:0] MS_L5     = 5'd14;
    localparam logic [4:0] MS_L6     = 5'd15;
    localparam logic [4:0] MS_ACC    = 5'd16;
    localparam logic [4:0] MS_AMP    = 5'd17;

    // hash step codes
    localparam logic [3:0] HS_PX     = 4'd0;
    localparam logic [3:0] HS_PX1    = 4'd1;
    localparam logic [3:0] HS_AA     = 4'd2;
    localparam logic [3:0] HS_AB     = 4'd3;
    localparam logic [3:0] HS_BA     = 4'd4;
    localparam logic [3:0] HS_BB     = 4'd5;
    localparam logic [3:0] HS_C0     = 4'd6;
    localparam logic [3:0] HS_LAST   = 4'd13;

    localparam logic [23:0] AMP_ONE  = 24'd65536;
    // setup step, then one step per numerator bit
    localparam logic [5:0]  DIV_LAST = 6'd48;

    function automatic logic signed [18:0] grad(input logic [3:0] h,
        input logic signed [17:0] gx, input logic signed [17:0] gy,
        input logic signed [17:0] gz);
        logic signed [18:0] gu;
        logic signed [18:0] gv;
        begin
            gu = (h < 4'd8) ? 19'(gx) : 19'(gy);
            gv = (h < 4'd4) ? 19'(gy) : ((h == 4'd12 || h == 4'd14) ? 19'(gx) : 19'(gz));
            if (h[0])
                gu = -gu;
            if (h[1])
                gv = -gv;
            return gu + gv;
        end
    endfunction

    // control state
    eng_state_t  state_reg, state_next;
    logic [3:0]  hstep_reg, hstep_next;
    logic        hwait_reg, hwait_next;
    logic [4:0]  mstep_reg, mstep_next;
    logic        mphase_reg, mphase_next;
    logic [2:0]  oct_reg, oct_next;
    logic [5:0]  div_cnt_reg, div_cnt_next;

    // payload
    logic [7:0]  perm_mem [TABLE_SIZE];
    logic [7:0]  rd_addr;
    logic [7:0]  rd_data_reg;
    logic [23:0] base_x_reg, base_y_reg, base_z_reg;
    logic [2:0]  last_reg;
    logic [7:0]  px_reg, px1_reg, aa_reg, ab_reg, ba_reg, bb_reg;
    logic [3:0]  hash_reg [8];
    logic [15:0] t2_reg, t3_reg;
    logic [16:0] fu_reg, fv_reg, fw_reg;
    logic signed [19:0] lr_reg [7];
    logic signed [49:0] prod_reg;
    logic [23:0] amp_reg;
    logic [24:0] amp_sum_reg;
    logic signed [47:0] total_reg;
    logic        neg_reg;
    logic [47:0] num_reg;
    logic [27:0] dvs_reg;
    logic [27:0] rem_reg;

    logic        take, wr_en, hash_cap, math_wb, oct_done, div_step;
    logic [23:0] sx, sy, sz;
    logic [7:0]  ix, iy, iz;
    logic [15:0] fx, fy, fz, f_cur;
    logic signed [17:0] ox0, ox1, oy0, oy1, oz0, oz1;
    logic signed [18:0] g_arr [8];
    logic [23:0] q_full;
    logic signed [23:0] q_s;
    logic [20:0] q_clamp;
    logic signed [24:0] mul_a, mul_b;
    logic [16:0] lerp_t;
    logic signed [19:0] lerp_a, lerp_b;
    logic signed [20:0] lerp_d;
    logic signed [33:0] r16;
    logic signed [20:0] lerp_sum;
    logic [2:0]  last_calc;
    logic [47:0] mag;
    logic [28:0] rem_shift;
    logic        q_bit;
    logic [47:0] quo;

    // lattice position of the current octave
    always_comb
    begin
        sx  = 24'(base_x_reg << oct_reg);
        sy  = 24'(base_y_reg << oct_reg);
        sz  = 24'(base_z_reg << oct_reg);
        ix  = sx[23:16];
        iy  = sy[23:16];
        iz  = sz[23:16];
        fx  = sx[15:0];
        fy  = sy[15:0];
        fz  = sz[15:0];
        ox0 = $signed({2'b00, fx});
        oy0 = $signed({2'b00, fy});
        oz0 = $signed({2'b00, fz});
        ox1 = ox0 - 18'sd65536;
        oy1 = oy0 - 18'sd65536;
        oz1 = oz0 - 18'sd65536;
    end

    // corner gradients; corner k has x, y, z offsets picked by bits 0, 1, 2
    always_comb
    begin
        for (int k = 0; k < 8; k++)
        begin
            g_arr[k] = grad(hash_reg[k], (k % 2 == 1) ? ox1 : ox0,
                            ((k / 2) % 2 == 1) ? oy1 : oy0,
                            ((k / 4) % 2 == 1) ? oz1 : oz0);
        end
    end

    // table read address for each hash step
    always_comb
    begin
        case (hstep_reg)
            4'd0:    rd_addr = ix;
            4'd1:    rd_addr = ix + 8'd1;
            4'd2:    rd_addr = px_reg + iy;
            4'd3:    rd_addr = px_reg + iy + 8'd1;
            4'd4:    rd_addr = px1_reg + iy;
            4'd5:    rd_addr = px1_reg + iy + 8'd1;
            4'd6:    rd_addr = aa_reg;
            4'd7:    rd_addr = ba_reg;
            4'd8:    rd_addr = ab_reg;
            4'd9:    rd_addr = bb_reg;
            4'd10:   rd_addr = aa_reg + 8'd1;
            4'd11:   rd_addr = ba_reg + 8'd1;
            4'd12:   rd_addr = ab_reg + 8'd1;
            4'd13:   rd_addr = bb_reg + 8'd1;
            default: rd_addr = ix;
        endcase
    end

    // permutation table
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            perm_mem[cmd.index] <= cmd.value;
        end
        rd_data_reg <= perm_mem[rd_addr];
    end

    // fade polynomial term, clamped at zero
    always_comb
    begin
        if (mstep_reg < MS_Y_T2)
            f_cur = fx;
        else if (mstep_reg < MS_Z_T2)
            f_cur = fy;
        else
            f_cur = fz;
        q_full  = 24'd655360 + 24'(t2_reg) * 24'd6 - 24'(f_cur) * 24'd15;
        q_s     = $signed(q_full);
        q_clamp = q_s[23] ? 21'd0 : q_s[20:0];
    end

    // lerp operands
    always_comb
    begin
        case (mstep_reg)
            MS_L0:   begin lerp_t = fu_reg; lerp_a = 20'(g_arr[0]); lerp_b = 20'(g_arr[1]); end
            MS_L1:   begin lerp_t = fu_reg; lerp_a = 20'(g_arr[2]); lerp_b = 20'(g_arr[3]); end
            MS_L2:   begin lerp_t = fv_reg; lerp_a = lr_reg[0];     lerp_b = lr_reg[1];     end
            MS_L3:   begin lerp_t = fu_reg; lerp_a = 20'(g_arr[4]); lerp_b = 20'(g_arr[5]); end
            MS_L4:   begin lerp_t = fu_reg; lerp_a = 20'(g_arr[6]); lerp_b = 20'(g_arr[7]); end
            MS_L5:   begin lerp_t = fv_reg; lerp_a = lr_reg[3];     lerp_b = lr_reg[4];     end
            MS_L6:   begin lerp_t = fw_reg; lerp_a = lr_reg[2];     lerp_b = lr_reg[5];     end
            default: begin lerp_t = fu_reg; lerp_a = lr_reg[0];     lerp_b = lr_reg[1];     end
        endcase
        lerp_d = 21'(lerp_b) - 21'(lerp_a);
    end

    // shared multiplier operands
    always_comb
    begin
        case (mstep_reg)
            MS_X_T2, MS_Y_T2, MS_Z_T2:
            begin
                mul_a = $signed({9'd0, f_cur});
                mul_b = $signed({9'd0, f_cur});
            end
            MS_X_T3, MS_Y_T3, MS_Z_T3:
            begin
                mul_a = $signed({9'd0, t2_reg});
                mul_b = $signed({9'd0, f_cur});
            end
            MS_X_FADE, MS_Y_FADE, MS_Z_FADE:
            begin
                mul_a = $signed({9'd0, t3_reg});
                mul_b = $signed({4'd0, q_clamp});
            end
            MS_ACC:
            begin
                mul_a = 25'(lr_reg[6]);
                mul_b = $signed({1'b0, amp_reg});
            end
            MS_AMP:
            begin
                mul_a = $signed({1'b0, amp_reg});
                mul_b = $signed({9'd0, persistence});
            end
            default:
            begin
                mul_a = $signed({8'd0, lerp_t});
                mul_b = 25'(lerp_d);
            end
        endcase
    end

    // rounding of the registered product
    always_comb
    begin
        r16      = 34'((prod_reg + 50'sd32768) >>> 16);
        lerp_sum = 21'(lerp_a) + r16[20:0];
    end

    // octave count clamp and divider step
    always_comb
    begin
        if (octave_count == 4'd0)
            last_calc = 3'd0;
        else if (octave_count > 4'(MAX_OCTAVES))
            last_calc = 3'(MAX_OCTAVES - 1);
        else
            last_calc = 3'(octave_count - 4'd1);
        mag       = total_reg[47] ? 48'(-total_reg) : 48'(total_reg);
        rem_shift = {rem_reg, num_reg[47]};
        q_bit     = (rem_shift >= {1'b0, dvs_reg});
        quo       = num_reg;
    end

    // result saturation
    always_comb
    begin
        if (neg_reg)
            res_noise = (quo > 48'd32768) ? -16'sd32768 : 16'(-$signed(quo));
        else
            res_noise = (quo > 48'd32767) ? 16'sd32767 : $signed(quo[15:0]);
    end

    // sequencer
    always_comb
    begin
        state_next   = state_reg;
        hstep_next   = hstep_reg;
        hwait_next   = hwait_reg;
        mstep_next   = mstep_reg;
        mphase_next  = mphase_reg;
        oct_next     = oct_reg;
        div_cnt_next = div_cnt_reg;
        cmd_ready    = 1'b0;
        res_valid    = 1'b0;
        take         = 1'b0;
        wr_en        = 1'b0;
        hash_cap     = 1'b0;
        math_wb      = 1'b0;
        oct_done     = 1'b0;
        div_step     = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                cmd_ready = 1'b1;
                if (cmd_valid)
                begin
                    take = 1'b1;
                    if (cmd.is_sample)
                    begin
                        state_next = ST_HASH;
                        hstep_next = HS_PX;
                        hwait_next = 1'b0;
                        oct_next   = 3'd0;
                    end
                    else
                    begin
                        wr_en = 1'b1;
                    end
                end
            end
            ST_HASH:
            begin
                hwait_next = !hwait_reg;
                if (hwait_reg)
                begin
                    hash_cap = 1'b1;
                    if (hstep_reg == HS_LAST)
                    begin
                        state_next  = ST_MATH;
                        mstep_next  = MS_X_T2;
                        mphase_next = 1'b0;
                    end
                    else
                    begin
                        hstep_next = hstep_reg + 4'd1;
                    end
                end
            end
            ST_MATH:
            begin
                mphase_next = !mphase_reg;
                if (mphase_reg)
                begin
                    math_wb = 1'b1;
                    if (mstep_reg == MS_AMP)
                    begin
                        if (oct_reg == last_reg)
                        begin
                            oct_done     = 1'b1;
                            state_next   = ST_DIV;
                            div_cnt_next = 6'd0;
                        end
                        else
                        begin
                            oct_next   = oct_reg + 3'd1;
                            state_next = ST_HASH;
                            hstep_next = HS_PX;
                            hwait_next = 1'b0;
                        end
                    end
                    else
                    begin
                        mstep_next = mstep_reg + 5'd1;
                    end
                end
            end
            ST_DIV:
            begin
                div_step     = 1'b1;
                div_cnt_next = div_cnt_reg + 6'd1;
                if (div_cnt_reg == DIV_LAST)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                res_valid = 1'b1;
                if (res_ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            hstep_reg   <= '0;
            hwait_reg   <= 1'b0;
            mstep_reg   <= '0;
            mphase_reg  <= 1'b0;
            oct_reg     <= '0;
            div_cnt_reg <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            hstep_reg   <= hstep_next;
            hwait_reg   <= hwait_next;
            mstep_reg   <= mstep_next;
            mphase_reg  <= mphase_next;
            oct_reg     <= oct_next;
            div_cnt_reg <= div_cnt_next;
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        if (take && cmd.is_sample)
        begin
            base_x_reg  <= cmd.x;
            base_y_reg  <= cmd.y;
            base_z_reg  <= cmd.z;
            last_reg    <= last_calc;
            amp_reg     <= AMP_ONE;
            amp_sum_reg <= '0;
            total_reg   <= '0;
        end

        // capture the registered table data in the cycle after its address
        if (hash_cap)
        begin
            case (hstep_reg)
                HS_PX:   px_reg  <= rd_data_reg;
                HS_PX1:  px1_reg <= rd_data_reg;
                HS_AA:   aa_reg  <= rd_data_reg + iz;
                HS_AB:   ab_reg  <= rd_data_reg + iz;
                HS_BA:   ba_reg  <= rd_data_reg + iz;
                HS_BB:   bb_reg  <= rd_data_reg + iz;
                default: hash_reg[3'(hstep_reg - HS_C0)] <= rd_data_reg[3:0];
            endcase
        end

        // multiply, then write back on the next cycle
        if (state_reg == ST_MATH && !mphase_reg)
        begin
            prod_reg <= mul_a * mul_b;
        end
        if (math_wb)
        begin
            case (mstep_reg)
                MS_X_T2, MS_Y_T2, MS_Z_T2: t2_reg <= r16[15:0];
                MS_X_T3, MS_Y_T3, MS_Z_T3: t3_reg <= r16[15:0];
                MS_X_FADE: fu_reg <= (r16 > 34'sd65536) ? 17'd65536 : r16[16:0];
                MS_Y_FADE: fv_reg <= (r16 > 34'sd65536) ? 17'd65536 : r16[16:0];
                MS_Z_FADE: fw_reg <= (r16 > 34'sd65536) ? 17'd65536 : r16[16:0];
                MS_ACC:
                begin
                    total_reg   <= total_reg + 48'(prod_reg);
                    amp_sum_reg <= amp_sum_reg + 25'(amp_reg);
                end
                MS_AMP:
                begin
                    amp_reg <= 24'((prod_reg + 50'sd16384) >>> 15);
                end
                default:
                begin
                    lr_reg[3'(mstep_reg - MS_L0)] <= lerp_sum[19:0];
                end
            endcase
        end

        // divider setup: (2|total| + den) / (2 den), den = 4 * amplitude sum
        if (oct_done)
        begin
            neg_reg <= total_reg[47];
        end
        if (div_step && div_cnt_reg == 6'd0)
        begin
            num_reg <= {mag[46:0], 1'b0} + {21'd0, amp_sum_reg, 2'b00};
            dvs_reg <= {amp_sum_reg, 3'b000};
            rem_reg <= '0;
        end
        else if (div_step)
        begin
            rem_reg <= q_bit ? 28'(rem_shift - {1'b0, dvs_reg}) : rem_shift[27:0];
            num_reg <= {num_reg[46:0], q_bit};
        end
    end

endmodule

// ===== rtl/perlin_noise_3d_octaves.sv =====
// Perlin noise block: a table load is written while the engine is idle; a sample
// runs, for each octave, the corner hashes (serialized on the single table read
// port) and then the fade, blend and weighting steps (on the one shared
// multiplier), then the final restoring division, and hands the result over.
// A two-beat command queue sits in front of the engine and a result register
// after it, so input beats are taken while a result waits to be popped.
// The permutation table must be loaded before sampling; unloaded entries are
// undefined. Depends on pn3_pkg, pn3_front and pn3_engine.
module perlin_noise_3d_octaves
    import pn3_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    output logic               full,
    input  logic               action,
    input  logic [7:0]         table_index,
    input  logic [7:0]         table_value,
    input  logic [23:0]        coord_x,
    input  logic [23:0]        coord_y,
    input  logic [23:0]        coord_z,
    output logic               empty,
    input  logic               pop,
    output logic signed [15:0] noise_value,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [2:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    logic [3:0]         octave_count_reg;
    logic [15:0]        persistence_reg;
    logic               cfg_wr;
    logic               cmd_valid, cmd_ready;
    cmd_t               cmd_q;
    logic               res_valid, res_ready;
    logic signed [15:0] res_noise;
    logic               full_reg, full_next;
    logic signed [15:0] noise_reg;

    // configuration registers
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            octave_count_reg <= OCTAVES_RST;
            persistence_reg  <= PERSIST_RST;
        end
        else if (cfg_wr)
        begin
            case (paddr[2])
                REG_OCTAVES: octave_count_reg <= pwdata[3:0];
                REG_PERSIST: persistence_reg  <= pwdata[15:0];
                default:     octave_count_reg <= octave_count_reg;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[2])
            REG_OCTAVES: prdata = {28'd0, octave_count_reg};
            REG_PERSIST: prdata = {16'd0, persistence_reg};
            default:     prdata = '0;
        endcase
    end

    pn3_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (push),
        .full        (full),
        .action      (action),
        .table_index (table_index),
        .table_value (table_value),
        .coord_x     (coord_x),
        .coord_y     (coord_y),
        .coord_z     (coord_z),
        .cmd_valid   (cmd_valid),
        .cmd_ready   (cmd_ready),
        .cmd         (cmd_q)
    );

    pn3_engine u_engine (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd_valid    (cmd_valid),
        .cmd_ready    (cmd_ready),
        .cmd          (cmd_q),
        .octave_count (octave_count_reg),
        .persistence  (persistence_reg),
        .res_valid    (res_valid),
        .res_ready    (res_ready),
        .res_noise    (res_noise)
    );

    // result register
    assign res_ready   = !full_reg || pop;
    assign empty       = !full_reg;
    assign noise_value = noise_reg;

    always_comb
    begin
        full_next = full_reg;
        if (res_valid && res_ready)
            full_next = 1'b1;
        else if (pop)
            full_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            full_reg <= 1'b0;
        else
            full_reg <= full_next;
    end

    always_ff @(posedge clk)
    begin
        if (res_valid && res_ready)
            noise_reg <= res_noise;
    end

    // a waiting result holds until popped
    a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
        (full_reg && !pop) |=> (full_reg && $stable(noise_reg)))
        else $error("result register changed while not popped");

    // the engine is not ready again in the cycle after it takes a sample
    a_sample_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd_valid && cmd_ready && cmd_q.is_sample) |=> !cmd_ready)
        else $error("engine took a new beat right after a sample");

    // engine holds its finished result until the result register takes it
    a_engine_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && !res_ready) |=> (res_valid && $stable(res_noise)))
        else $error("engine dropped a finished result");

endmodule
